FILE: design/mspwm_pkg.sv
// ----------------------------------------------------------------------------
// mspwm_pkg - shared types and constants of the software PWM engine
// Action and status codes, table size and the field widths.
// ----------------------------------------------------------------------------
package mspwm_pkg;

  localparam int CHANNELS = 8;
  localparam int SLOT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = 24;
  localparam int PIN_W    = 7;
  localparam logic [CNT_W-1:0] TICK_RATE_RESET = 24'd8000;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_PULSE_H = 3'd2,
    ACT_PULSE_L = 3'd3,
    ACT_REMOVE  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SLOT   = 3'd1,
    ST_RANGE     = 3'd2,
    ST_RESOLUTION = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [PIN_W-1:0] pin;
    logic [CNT_W-1:0] frequency;
    logic [6:0]       duty;
    logic [CNT_W-1:0] pulse_ticks;
    logic [CNT_W-1:0] dead_ticks;
  } cmd_t;

  typedef struct packed {
    logic             is_status;
    logic [2:0]       status;
    logic             drive_valid;
    logic [PIN_W-1:0] drive_pin;
    logic             level;
    logic             last;
  } res_t;

  // 100 / d for d in 1..99: the largest q with q * d not above 100
  function automatic logic [6:0] pct_quot(input logic [6:0] d);
    logic [6:0] q;
    q = 7'd1;
    for (int k = 1; k <= 100; k++) begin
      if (14'(d) * 14'(k) <= 14'd100) begin
        q = 7'(k);
      end
    end
    return q;
  endfunction

endpackage

FILE: design/mspwm_if.sv
// ----------------------------------------------------------------------------
// mspwm_if - valid/ready channel carrying one payload beat
// Generic stream interface with source and sink views.
// ----------------------------------------------------------------------------
interface mspwm_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mspwm_div.sv
// ----------------------------------------------------------------------------
// mspwm_div - radix-2 restoring divider
// Divides a 24-bit dividend by a 31-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mspwm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [23:0] quotient
);
  logic [23:0] num;
  logic [30:0] den;
  logic [31:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [31:0] trial;

  assign trial = {rem[30:0], num[23]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        rem  <= '0;
        num  <= dividend;
        den  <= divisor;
      end else if (busy) begin
        // shift in one dividend bit, subtract when it fits
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          num <= {num[22:0], 1'b1};
        end else begin
          rem <= trial;
          num <= {num[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = num;
endmodule

FILE: design/multichannel_soft_pwm_engine_core.sv
// A tick walks the slots one per cycle while the pending beat can move on, and passes
// through S_WAITD after each slot that toggles; an add runs two serial divisions before
// its beat; other commands walk the slot table at most once before the beat.
// Throughput: one item at a time; in_ch.ready is low while an item is in work.
// Results pass a pending beat and a one-beat output register; hold while both are full.
// Reset (rst, synchronous): all slots disabled with zero state, tick_rate 8000.
// ----------------------------------------------------------------------------
// multichannel_soft_pwm_engine_core - multichannel software PWM engine
// Slot table with a sequencer that walks slots and a shared divider.
// ----------------------------------------------------------------------------
module multichannel_soft_pwm_engine_core (
  input  logic clk,
  input  logic rst,
  mspwm_if.sink   in_ch,
  mspwm_if.source out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);
  import mspwm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SCAN   = 8'b00000010,  // walk slots for select/remove
    S_TICK   = 8'b00000100,  // walk slots for tick
    S_DIVH   = 8'b00001000,
    S_DIVL   = 8'b00010000,
    S_FINISH = 8'b00100000,
    S_EMIT   = 8'b01000000,  // load the status beat
    S_WAITD  = 8'b10000000
  } state_t;

  state_t state;
  cmd_t   cmd;
  logic [CNT_W-1:0] tick_rate;

  logic [CHANNELS-1:0] slot_enable, slot_phase;
  logic [PIN_W-1:0]    slot_pin  [CHANNELS];
  logic [CNT_W-1:0]    slot_high [CHANNELS];
  logic [CNT_W-1:0]    slot_low  [CHANNELS];
  logic [CNT_W-1:0]    slot_cnt  [CHANNELS];

  logic [SLOT_W:0]   idx;     // walk index, one bit wider than slot index
  logic [SLOT_W-1:0] sel;
  logic [SLOT_W-1:0] cur;
  logic              cur_hit;
  logic              later_fire;
  logic [CNT_W-1:0]  hi_q;

  // output register
  res_t out_q;
  logic out_v;
  res_t pend;
  logic pend_v;
  logic pend_take;
  logic pend_free;
  logic fire_now;
  logic pend_load;

  // divider
  logic        div_start, div_done;
  logic [30:0] div_den;
  logic [23:0] div_q;
  logic [6:0]  dh, dl;

  assign dh      = pct_quot(cmd.duty);
  assign dl      = pct_quot(7'(7'd100 - cmd.duty));
  assign cur     = idx[SLOT_W-1:0];
  assign cur_hit = (cmd.action == ACT_REMOVE) ? (slot_pin[cur] == cmd.pin)
                 : (!slot_enable[cur] || slot_pin[cur] == cmd.pin);

  // A tick beat is the last one when no later slot reaches zero on this walk;
  // later slots are still untouched while the walk sits at cur.
  always_comb begin
    later_fire = 1'b0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (k > int'(cur) && slot_enable[k] && slot_cnt[k] == '0) begin
        later_fire = 1'b1;
      end
    end
  end

  mspwm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(tick_rate),
    .divisor(div_den), .done(div_done), .quotient(div_q)
  );

  // pending beat moves on when the output register is empty or taken
  assign pend_take = pend_v && (!out_v || out_ch.ready);
  assign pend_free = !pend_v || pend_take;
  assign fire_now  = (state == S_TICK) && pend_free && (idx != (SLOT_W+1)'(CHANNELS))
                  && slot_enable[cur] && (slot_cnt[cur] == '0);
  assign pend_load = fire_now || (state == S_EMIT);

  assign in_ch.ready = (state == S_IDLE) && !pend_v;
  // take a tick_rate write only with nothing in flight and no item offered
  assign cfg_ready   = (state == S_IDLE) && !pend_v && !out_v && !in_ch.valid;
  assign out_ch.valid = out_v;
  assign out_ch.data  = out_q;

  function automatic res_t mk_status(input logic [2:0] st);
    res_t r;
    r = '0;
    r.is_status = 1'b1;
    r.status    = st;
    r.last      = 1'b1;
    return r;
  endfunction

  // output register: load a pending beat when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (!out_v || out_ch.ready) begin
      out_v <= pend_v;
      out_q <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (pend_load) begin
      pend_v <= 1'b1;
    end else if (pend_take) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tick_rate   <= TICK_RATE_RESET;
      slot_enable <= '0;
      slot_phase  <= '0;
      div_start   <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        slot_pin[k]  <= '0;
        slot_high[k] <= '0;
        slot_low[k]  <= '0;
        slot_cnt[k]  <= '0;
      end
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            tick_rate <= cfg_data;
          end
          if (in_ch.valid && in_ch.ready) begin
            cmd <= in_ch.data;
            idx <= '0;
            if (in_ch.data.action == ACT_TICK) begin
              state <= S_TICK;
            end else if (in_ch.data.action <= ACT_REMOVE) begin
              state <= S_SCAN;
            end
          end
        end
        S_TICK: begin
          // one slot per cycle, with a stop in S_WAITD after a toggle; hold while the pending beat cannot move on
          if (pend_free) begin
            if (idx == (SLOT_W+1)'(CHANNELS)) begin
              state <= S_IDLE;
            end else begin
              if (slot_enable[cur]) begin
                if (slot_cnt[cur] != '0) begin
                  slot_cnt[cur] <= slot_cnt[cur] - CNT_W'(1);
                end else begin
                  slot_cnt[cur]   <= slot_phase[cur] ? slot_low[cur] : slot_high[cur];
                  slot_phase[cur] <= !slot_phase[cur];
                  pend <= '{is_status: 1'b0, status: ST_OK, drive_valid: 1'b1,
                            drive_pin: slot_pin[cur], level: !slot_phase[cur],
                            last: !later_fire};
                  state  <= S_WAITD;
                end
              end
              idx <= idx + (SLOT_W+1)'(1);
            end
          end
        end
        S_WAITD: begin
          // pause the walk so the fresh pending beat can move on toward the output register
          state <= S_TICK;
        end
        S_SCAN: begin
          if (idx == (SLOT_W+1)'(CHANNELS)) begin
            pend   <= mk_status((cmd.action == ACT_REMOVE) ? ST_NOT_FOUND : ST_NO_SLOT);
            state  <= S_EMIT;
          end else if (cur_hit) begin
            sel <= cur;
            slot_enable[cur] <= 1'b0;
            slot_phase[cur]  <= 1'b0;
            state <= S_FINISH;
            if (cmd.action == ACT_REMOVE) begin
              pend  <= mk_status(ST_OK);
              state <= S_EMIT;
            end else if (cmd.action == ACT_ADD) begin
              if (cmd.duty > 7'd100 || cmd.frequency == '0) begin
                pend  <= mk_status(ST_RANGE);
                state <= S_EMIT;
              end else if (cmd.duty == 7'd0 || cmd.duty == 7'd100) begin
                slot_high[cur] <= '0;
                slot_low[cur]  <= '0;
                slot_cnt[cur]  <= '0;
                pend <= '{is_status: 1'b1, status: ST_OK, drive_valid: 1'b1,
                          drive_pin: cmd.pin, level: (cmd.duty == 7'd100),
                          last: 1'b1};
                state <= S_EMIT;
              end else begin
                div_den   <= 31'(cmd.frequency * dh);
                div_start <= 1'b1;
                state     <= S_DIVH;
              end
            end else begin
              slot_high[cur]   <= cmd.pulse_ticks;
              slot_low[cur]    <= cmd.dead_ticks;
              slot_pin[cur]    <= cmd.pin;
              slot_enable[cur] <= 1'b1;
              slot_cnt[cur]    <= (cmd.action == ACT_PULSE_H) ? cmd.dead_ticks
                                                              : cmd.pulse_ticks;
              slot_phase[cur]  <= (cmd.action == ACT_PULSE_H);
              pend <= '{is_status: 1'b1, status: ST_OK, drive_valid: 1'b1,
                        drive_pin: cmd.pin, level: (cmd.action == ACT_PULSE_L),
                        last: 1'b1};
              state <= S_EMIT;
            end
          end else begin
            idx <= idx + (SLOT_W+1)'(1);
          end
        end
        S_DIVH: begin
          if (div_done) begin
            hi_q      <= div_q;
            div_den   <= 31'(cmd.frequency * dl);
            div_start <= 1'b1;
            state     <= S_DIVL;
          end
        end
        S_DIVL: begin
          if (div_done) begin
            slot_high[sel] <= hi_q;
            slot_low[sel]  <= div_q;
            if ({1'b0, hi_q} + {1'b0, div_q} > {1'b0, tick_rate}) begin
              pend <= mk_status(ST_RESOLUTION);
            end else begin
              slot_enable[sel] <= 1'b1;
              slot_pin[sel]    <= cmd.pin;
              slot_cnt[sel]    <= hi_q;
              pend <= mk_status(ST_OK);
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // pend is empty here; pend_load presents the status beat
          state  <= S_FINISH;
        end
        S_FINISH: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_v && !out_ch.ready) |=> (out_v && $stable(out_q)))
    else $error("output beat changed while stalled");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVH || state == S_DIVL))
    else $error("divider finished outside a division step");
endmodule

FILE: dv/mspwm_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mspwm_tb_if - testbench package mspwm_tb_pkg, holding the drain settle constant
// No interface is defined here; the design interface mspwm_if is instanced directly.
// ----------------------------------------------------------------------------
package mspwm_tb_pkg;
  import mspwm_pkg::*;
  localparam int SETTLE_CYCLES = 80;
endpackage

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the multichannel software PWM engine
// Commands and ticks are queued by a stimulus block, driven with random gaps,
// and every result beat is checked against a slot-table model kept here.
// ----------------------------------------------------------------------------
module testbench;
  import mspwm_pkg::*;
  import mspwm_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  mspwm_if #(.payload_t(cmd_t)) cmd_ch (clk);
  mspwm_if #(.payload_t(res_t)) res_ch (clk);
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;

  multichannel_soft_pwm_engine_core uut (
    .clk(clk), .rst(rst), .in_ch(cmd_ch.sink), .out_ch(res_ch.source),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Model of the slot table.
  logic [23:0]      rate_m;
  logic             en_m   [CHANNELS];
  logic             ph_m   [CHANNELS];
  logic [PIN_W-1:0] pin_m  [CHANNELS];
  logic [23:0]      hi_m   [CHANNELS];
  logic [23:0]      lo_m   [CHANNELS];
  logic [23:0]      cnt_m  [CHANNELS];

  cmd_t pending_cmds[$];
  res_t expected_beats[$];
  int   errors = 0;
  bit   calm = 1'b0;      // no idling in the last stretch
  bit   cmd_acc = 1'b0;   // command beat taken at the last rising edge
  int   stall_left = 0, gap_left = 0, quiet = 0;

  function automatic res_t status_beat(status_t st);
    res_t r;
    r = '0;
    r.is_status = 1'b1;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Pick the first free slot or the one holding the pin; clear it.
  function automatic int claim_slot(logic [PIN_W-1:0] p);
    for (int i = 0; i < CHANNELS; i++) begin
      if (!en_m[i] || pin_m[i] == p) begin
        en_m[i] = 1'b0;
        ph_m[i] = 1'b0;
        return i;
      end
    end
    return CHANNELS;
  endfunction

  // Advance the model by one command and queue the beats it causes.
  task automatic predict_engine(cmd_t c);
    res_t r;
    int s, n;
    logic [63:0] hi, lo;
    n = expected_beats.size();
    r = '0;
    case (c.action)
      ACT_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (en_m[i]) begin
            if (cnt_m[i] != 0) begin
              cnt_m[i] = cnt_m[i] - 1'b1;
            end else begin
              r = '0;
              r.drive_valid = 1'b1;
              r.drive_pin = pin_m[i];
              r.level = ~ph_m[i];
              cnt_m[i] = ph_m[i] ? lo_m[i] : hi_m[i];
              ph_m[i] = ~ph_m[i];
              expected_beats.push_back(r);
            end
          end
        end
        if (expected_beats.size() > n) expected_beats[$].last = 1'b1;
      end
      ACT_REMOVE: begin
        s = CHANNELS;
        for (int i = 0; i < CHANNELS; i++) begin
          if (s == CHANNELS && pin_m[i] == c.pin) s = i;
        end
        if (s < CHANNELS) begin
          en_m[s] = 1'b0;
          ph_m[s] = 1'b0;
          expected_beats.push_back(status_beat(ST_OK));
        end else begin
          expected_beats.push_back(status_beat(ST_NOT_FOUND));
        end
      end
      ACT_ADD, ACT_PULSE_H, ACT_PULSE_L: begin
        s = claim_slot(c.pin);
        if (s == CHANNELS) begin
          expected_beats.push_back(status_beat(ST_NO_SLOT));
        end else if (c.action == ACT_ADD) begin
          if (c.duty > 7'd100 || c.frequency == 0) begin
            expected_beats.push_back(status_beat(ST_RANGE));
          end else if (c.duty == 0 || c.duty == 7'd100) begin
            hi_m[s] = '0;
            lo_m[s] = '0;
            cnt_m[s] = '0;
            r = status_beat(ST_OK);
            r.drive_valid = 1'b1;
            r.drive_pin = c.pin;
            r.level = (c.duty == 7'd100);
            expected_beats.push_back(r);
          end else begin
            hi = 64'(rate_m) / (64'(c.frequency) * 64'(100 / int'(c.duty)));
            lo = 64'(rate_m) / (64'(c.frequency) * 64'(100 / (100 - int'(c.duty))));
            hi_m[s] = hi[23:0];
            lo_m[s] = lo[23:0];
            if (hi + lo > 64'(rate_m)) begin
              expected_beats.push_back(status_beat(ST_RESOLUTION));
            end else begin
              en_m[s] = 1'b1;
              pin_m[s] = c.pin;
              cnt_m[s] = hi[23:0];
              expected_beats.push_back(status_beat(ST_OK));
            end
          end
        end else begin
          hi_m[s] = c.pulse_ticks;
          lo_m[s] = c.dead_ticks;
          pin_m[s] = c.pin;
          en_m[s] = 1'b1;
          ph_m[s] = (c.action == ACT_PULSE_H);
          cnt_m[s] = (c.action == ACT_PULSE_H) ? c.dead_ticks : c.pulse_ticks;
          r = status_beat(ST_OK);
          r.drive_valid = 1'b1;
          r.drive_pin = c.pin;
          r.level = (c.action == ACT_PULSE_L);
          expected_beats.push_back(r);
        end
      end
      default: ;  // unknown actions are dropped by the engine
    endcase
  endtask

  // Driver: present queued commands at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data <= '0;
    end else if (cmd_ch.valid && !cmd_acc) begin
      // hold the beat until taken
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      cmd_ch.valid <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 11);
        cmd_ch.valid <= 1'b0;
      end else begin
        cmd_ch.data <= pending_cmds.pop_front();
        cmd_ch.valid <= 1'b1;
      end
    end else begin
      cmd_ch.valid <= 1'b0;
    end
  end

  // Result sink: random stall bursts on ready.
  always @(negedge clk) begin
    if (rst || calm) begin
      res_ch.ready <= !rst;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 11);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on accepted commands, check accepted results.
  always @(posedge clk) begin
    res_t want, got;
    if (rst) begin
      cmd_acc <= 1'b0;
    end else begin
      cmd_acc <= cmd_ch.valid && cmd_ch.ready;
      quiet <= ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
               ? 0 : quiet + 1;
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_engine(cmd_ch.data);
      end
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat %h", got);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (got.is_status !== want.is_status) begin
            $error("is_status exp %0d got %0d", want.is_status, got.is_status); errors++;
          end
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); errors++;
          end
          if (got.drive_valid !== want.drive_valid) begin
            $error("drive_valid exp %0d got %0d", want.drive_valid, got.drive_valid);
            errors++;
          end
          if (got.drive_pin !== want.drive_pin) begin
            $error("drive_pin exp %0d got %0d", want.drive_pin, got.drive_pin); errors++;
          end
          if (got.level !== want.level) begin
            $error("level exp %0d got %0d", want.level, got.level); errors++;
          end
          if (got.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, got.last); errors++;
          end
        end
      end
      if (quiet > 20000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic cmd_t make_cmd(action_t a, int p, int f, int d, int pt, int dt);
    cmd_t c;
    c.action = a;
    c.pin = p[6:0];
    c.frequency = f[23:0];
    c.duty = d[6:0];
    c.pulse_ticks = pt[23:0];
    c.dead_ticks = dt[23:0];
    return c;
  endfunction

  // Random command; mostly small counts and a small pin pool so slots recycle.
  function automatic cmd_t random_cmd();
    cmd_t c;
    logic [95:0] raw;
    int k;
    raw = {$urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 45) c.action = ACT_TICK;
    else if (k < 65) c.action = ACT_ADD;
    else if (k < 77) c.action = ACT_PULSE_H;
    else if (k < 89) c.action = ACT_PULSE_L;
    else if (k < 97) c.action = ACT_REMOVE;
    else c.action = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 3) != 0) c.pin = 7'($urandom_range(0, 11));
    if ($urandom_range(0, 4) != 0) begin
      c.pulse_ticks = 24'($urandom_range(0, 6));
      c.dead_ticks = 24'($urandom_range(0, 6));
    end
    if ($urandom_range(0, 4) != 0) begin
      c.duty = 7'($urandom_range(0, 101));
      c.frequency = 24'($urandom_range(0, 2000));
    end
    return c;
  endfunction

  // Wait for the engine to drain, then let in-flight work settle.
  task automatic drain();
    wait (pending_cmds.size() == 0 && !cmd_ch.valid);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write tick_rate while the engine is idle.
  task automatic write_rate(logic [23:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rate_m = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [23:0] rates[5];
    rate_m = TICK_RATE_RESET;
    for (int i = 0; i < CHANNELS; i++) begin
      en_m[i] = 0; ph_m[i] = 0; pin_m[i] = '0;
      hi_m[i] = '0; lo_m[i] = '0; cnt_m[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: remove after reset finds stale pin 0, every action and edge.
    pending_cmds.push_back(make_cmd(ACT_REMOVE, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_REMOVE, 127, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ADD, 1, 0, 50, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ADD, 1, 100, 101, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ADD, 2, 100, 127, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ADD, 3, 100, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ADD, 4, 100, 100, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ADD, 5, 1000, 50, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ADD, 6, 1, 1, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_ADD, 7, 16777215, 99, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_PULSE_H, 127, 0, 0, 1, 2));
    pending_cmds.push_back(make_cmd(ACT_PULSE_L, 96, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_PULSE_L, 96, 0, 0, 16777215, 16777215));
    pending_cmds.push_back(make_cmd(ACT_PULSE_H, 8, 0, 0, 2, 1));
    pending_cmds.push_back(make_cmd(ACT_PULSE_H, 8, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_PULSE_L, 9, 0, 0, 1, 1));
    pending_cmds.push_back(make_cmd(ACT_PULSE_L, 10, 0, 0, 3, 0));
    pending_cmds.push_back(make_cmd(ACT_PULSE_H, 11, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(ACT_PULSE_H, 12, 0, 0, 1, 1));  // table full
    pending_cmds.push_back(cmd_t'({3'd5, 7'h7f, 24'hffffff, 7'h7f, 48'hffffffffffff}));
    for (int i = 0; i < 4; i++) pending_cmds.push_back(make_cmd(ACT_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_REMOVE, 96, 0, 0, 0, 0));
    drain();

    // Random phases across tick_rate settings, including zero and the extremes.
    rates = '{24'd0, 24'd1, 24'hffffff, 24'd100, 24'd8000};
    for (int ph = 0; ph < 5; ph++) begin
      write_rate(rates[ph]);
      if (ph == 4) calm = 1'b1;
      for (int n = 0; n < 31; n++) pending_cmds.push_back(random_cmd());
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
